/* sv/wpfp_pkg.sv */
// Shared constants, register codes and pattern tables for the window pattern fill pass.
`timescale 1ns / 1ps
`default_nettype none

package wpfp_pkg;

  // Field and port widths
  localparam int PIX_W   = 8;
  localparam int LW_W    = 12;
  localparam int CNT_W   = 24;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Line width limits
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MIN_WIDTH     = 3;

  // Saturation value of the pass counters
  localparam logic [CNT_W-1:0] CNT_MAX = 24'hFF_FFFF;

  // Register reset values
  localparam logic             PATTERN_RST    = 1'b0;
  localparam logic [PIX_W-1:0] THRESHOLD_RST  = 8'd90;
  localparam logic [PIX_W-1:0] FILL_RST       = 8'd70;
  localparam logic [LW_W-1:0]  LINE_WIDTH_RST = 12'd2048;

  // Pattern set select codes
  localparam logic PAT_TJUNC    = 1'b0;
  localparam logic PAT_LINE_END = 1'b1;

  // Register map, one word per register
  typedef enum logic [1:0] {
    REG_PATTERN_SET = 2'd0,
    REG_THRESHOLD   = 2'd1,
    REG_FILL_VALUE  = 2'd2,
    REG_LINE_WIDTH  = 2'd3
  } cfg_reg_t;

  typedef logic [7:0] mask_t;

  // Line-end patterns: isolated ends and short spurs
  function automatic logic in_end_set(input mask_t m);
    logic hit;
    case (m) inside
      8'hA7, 8'hCB, 8'hBC, 8'h7A, 8'hE9, 8'h2F, 8'h9E, 8'hF2,
      8'hBE, 8'hFA, 8'hAF, 8'hEB, 8'hE0, 8'h0E, 8'h83, 8'h38,
      8'h06, 8'h0C, 8'h30, 8'h18, 8'hC0, 8'h60, 8'h81, 8'h03: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // T-junction patterns
  function automatic logic in_t_set(input mask_t m);
    logic hit;
    case (m) inside
      8'h2B, 8'hA9, 8'hA6, 8'hAC, 8'h9A, 8'hB2,
      8'h6A, 8'hCA, 8'hAE, 8'hEA, 8'hAB, 8'hBA: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

`default_nettype wire

/* sv/wpfp_ram.sv */
// Generic single-write, single-read memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module wpfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4099
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/window_pattern_fill_pass.sv */
// Top level: in-place 3x3 pattern fill pass over a raster pixel stream.
//
//  channel  | handshake                  | beat contents
//  ---------+----------------------------+------------------------------------------
//  pixel    | pixel_valid / pixel_stall  | pixel, last_pixel
//  result   | result_valid / result_stall| centre_value, changed, fill_count, pass_done
//  config   | psel penable pwrite pready | paddr, pwdata, prdata
//
//  One pixel per cycle unless stalled; a window's result leaves the cycle after its pixel.
//  The 3x3 window lives in two memories (raw pixels, final centres) read ahead of each pixel
//  plus tap registers; the one write port per memory sets the one-pixel-per-cycle rate.
//  A line_width write that changes the effective width starts a copy sweep between the
//  memories (S_SW_RD, S_SW_WR per unit of width change), then tap reload in S_LD_A to S_LD_D;
//  pixels stall meanwhile. Reset: synchronous; ready again the cycle after reset, no clear pass.
//  A stalled result holds in the output register and blocks pixels only while it waits.
`timescale 1ns / 1ps
`default_nettype none

module window_pattern_fill_pass #(
  parameter int MAX_WIDTH = wpfp_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wpfp_pkg::PADDR_W-1:0]  paddr,
  input  logic [wpfp_pkg::PDATA_W-1:0]  pwdata,
  output logic [wpfp_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  // pixel stream
  input  logic                          pixel_valid,
  output logic                          pixel_stall,
  input  logic [wpfp_pkg::PIX_W-1:0]    pixel,
  input  logic                          last_pixel,
  // result stream
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [wpfp_pkg::PIX_W-1:0]    centre_value,
  output logic                          changed,
  output logic [wpfp_pkg::CNT_W-1:0]    fill_count,
  output logic                          pass_done
);

  import wpfp_pkg::*;

  localparam int DEPTH = 2 * MAX_WIDTH + 3;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CW    = (WW > LW_W) ? WW : LW_W;
  localparam int W_RST = (int'(LINE_WIDTH_RST) > MAX_WIDTH) ? MAX_WIDTH :
                         ((int'(LINE_WIDTH_RST) < MIN_WIDTH) ? MIN_WIDTH :
                          int'(LINE_WIDTH_RST));

  // Mask bit positions
  localparam int MB_RIGHT     = 0;
  localparam int MB_TOP_RIGHT = 1;
  localparam int MB_TOP       = 2;
  localparam int MB_TOP_LEFT  = 3;
  localparam int MB_LEFT      = 4;
  localparam int MB_BOT_LEFT  = 5;
  localparam int MB_BOT       = 6;
  localparam int MB_BOT_RIGHT = 7;

  typedef enum logic [2:0] {
    S_RUN,
    S_SW_RD,
    S_SW_WR,
    S_LD_A,
    S_LD_B,
    S_LD_C,
    S_LD_D
  } state_t;

  // Circular position helpers over the delay line
  function automatic logic [AW-1:0] pos_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] pos_back(input logic [AW-1:0] p,
                                             input logic [AW-1:0] d);
    logic [AW:0] s;
    s = {1'b0, p} + (AW+1)'(DEPTH) - {1'b0, d};
    return (p >= d) ? (p - d) : s[AW-1:0];
  endfunction

  // Configuration registers
  logic             pattern_set;
  logic [PIX_W-1:0] threshold;
  logic [PIX_W-1:0] fill_value;
  logic [LW_W-1:0]  line_width;

  // Control state
  state_t           state;
  logic [AW-1:0]    wpos;
  logic [WW-1:0]    weff;
  logic [CNT_W-1:0] pixels_seen;
  logic [CNT_W-1:0] fills_done;

  // Sweep step held between its read and write cycles
  logic [AW-1:0]    sweep_addr;
  logic             sweep_dec;

  // Window taps kept in registers
  logic [PIX_W-1:0] n0, n1;   // ages 1 and 2 at the next pixel
  logic [PIX_W-1:0] b1, b2;   // centre and left at the next pixel
  logic [PIX_W-1:0] c1, c2;   // top and top-left at the next pixel

  // Memory ports
  logic             r_we, f_we;
  logic [AW-1:0]    r_waddr, f_waddr, r_raddr, f_raddr;
  logic [PIX_W-1:0] r_wdata, f_wdata, r_rdata, f_rdata;

  logic             cfg_wr;
  cfg_reg_t         cfg_sel;
  logic [WW-1:0]    target;
  logic [CW-1:0]    lw_ext;
  logic             accept;
  logic [AW-1:0]    wpos_inc, head, nxt, centre_pos, sweep_pos;
  logic [AW-1:0]    w_age, w_age1, w_age2, w_age2p1;
  logic [CNT_W-1:0] ps_next, fills_next, span;
  logic             win, hit;
  mask_t            mask;
  logic [PIX_W-1:0] ctr_final;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_sel = cfg_reg_t'(paddr[3:2]);

  // Read back registers
  always_comb begin
    unique case (cfg_sel)
      REG_PATTERN_SET: prdata = PDATA_W'(pattern_set);
      REG_THRESHOLD:   prdata = PDATA_W'(threshold);
      REG_FILL_VALUE:  prdata = PDATA_W'(fill_value);
      REG_LINE_WIDTH:  prdata = PDATA_W'(line_width);
    endcase
  end

  // Clamp the programmed width into the supported range
  always_comb begin
    lw_ext = CW'(line_width);
    if (lw_ext < CW'(MIN_WIDTH)) begin
      target = WW'(MIN_WIDTH);
    end else if (lw_ext > CW'(MAX_WIDTH)) begin
      target = WW'(MAX_WIDTH);
    end else begin
      target = WW'(lw_ext);
    end
  end

  // Accept only with the taps built for the programmed width and no stalled result waiting
  assign pixel_stall = rst | (state != S_RUN) | (weff != target) |
                       (result_valid & result_stall);
  assign accept      = pixel_valid & ~pixel_stall;

  // Positions and tap distances
  assign w_age      = AW'(weff);
  assign w_age1     = w_age + AW'(1);
  assign w_age2     = AW'({weff, 1'b0});
  assign w_age2p1   = w_age2 + AW'(1);
  assign wpos_inc   = pos_inc(wpos);
  assign head       = accept ? wpos_inc : wpos;
  assign nxt        = pos_inc(head);
  assign centre_pos = pos_back(wpos, w_age);
  assign sweep_pos  = (weff > target) ? pos_back(wpos, w_age) : pos_back(wpos, w_age1);

  // Read addresses: prefetch the next pixel's right and top-right taps while running or in S_LD_D
  always_comb begin
    r_raddr = pos_back(wpos, w_age);
    f_raddr = pos_back(wpos, w_age1);
    unique case (state)
      S_RUN, S_LD_D: begin
        r_raddr = pos_back(nxt, w_age);
        f_raddr = pos_back(nxt, w_age2);
      end
      S_SW_RD: begin
        r_raddr = sweep_pos;
        f_raddr = sweep_pos;
      end
      S_SW_WR: begin
        r_raddr = sweep_addr;
        f_raddr = sweep_addr;
      end
      S_LD_A: begin
        r_raddr = pos_back(wpos, w_age);
        f_raddr = pos_back(wpos, w_age1);
      end
      S_LD_B: f_raddr = pos_back(wpos, w_age2);
      S_LD_C: f_raddr = pos_back(wpos, w_age2p1);
    endcase
  end

  // Window evaluation on the accepted pixel
  assign ps_next = (pixels_seen == CNT_MAX) ? pixels_seen : pixels_seen + CNT_W'(1);
  assign span    = CNT_W'({weff, 1'b0}) + CNT_W'(3);
  assign win     = ps_next >= span;

  always_comb begin
    mask               = '0;
    mask[MB_TOP_LEFT]  = c2 <= threshold;
    mask[MB_TOP]       = c1 <= threshold;
    mask[MB_TOP_RIGHT] = f_rdata <= threshold;
    mask[MB_RIGHT]     = r_rdata <= threshold;
    mask[MB_LEFT]      = b2 <= threshold;
    mask[MB_BOT_LEFT]  = n1 <= threshold;
    mask[MB_BOT]       = n0 <= threshold;
    mask[MB_BOT_RIGHT] = pixel <= threshold;
  end

  assign hit = win & (b1 > threshold) &
               ((pattern_set == PAT_LINE_END) ? in_end_set(mask) : in_t_set(mask));
  assign ctr_final  = hit ? fill_value : b1;
  assign fills_next = (hit && fills_done != CNT_MAX) ? fills_done + CNT_W'(1) : fills_done;

  // Raw pixels go in at the head; final centres go in a width behind, or the sweep copies
  assign r_we    = accept | ((state == S_SW_WR) & ~sweep_dec);
  assign r_waddr = accept ? wpos_inc : sweep_addr;
  assign r_wdata = accept ? pixel : f_rdata;
  assign f_we    = accept | ((state == S_SW_WR) & sweep_dec);
  assign f_waddr = accept ? centre_pos : sweep_addr;
  assign f_wdata = accept ? ctr_final : r_rdata;

  wpfp_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_raw_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata (r_wdata),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  wpfp_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_final_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  // Sequencer, counters, taps and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_RUN;
      wpos         <= '0;
      weff         <= WW'(W_RST);
      pixels_seen  <= '0;
      fills_done   <= '0;
      result_valid <= 1'b0;
      pattern_set  <= PATTERN_RST;
      threshold    <= THRESHOLD_RST;
      fill_value   <= FILL_RST;
      line_width   <= LINE_WIDTH_RST;
    end else begin
      // register writes
      if (cfg_wr) begin
        unique case (cfg_sel)
          REG_PATTERN_SET: pattern_set <= pwdata[0];
          REG_THRESHOLD:   threshold   <= pwdata[PIX_W-1:0];
          REG_FILL_VALUE:  fill_value  <= pwdata[PIX_W-1:0];
          REG_LINE_WIDTH:  line_width  <= pwdata[LW_W-1:0];
        endcase
      end

      // hold a result until taken
      if (accept && win) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      // advance the pass
      if (accept) begin
        wpos        <= wpos_inc;
        pixels_seen <= last_pixel ? '0 : ps_next;
        fills_done  <= last_pixel ? '0 : fills_next;
      end

      // width change: sweep one position at a time, then reload the taps
      unique case (state)
        S_RUN: begin
          if (weff != target) state <= S_SW_RD;
        end
        S_SW_RD: begin
          if (weff == target) begin
            state <= S_LD_A;
          end else begin
            sweep_dec  <= weff > target;
            sweep_addr <= sweep_pos;
            state      <= S_SW_WR;
          end
        end
        S_SW_WR: begin
          weff  <= sweep_dec ? weff - WW'(1) : weff + WW'(1);
          state <= S_SW_RD;
        end
        S_LD_A: state <= (weff != target) ? S_SW_RD : S_LD_B;
        S_LD_B: state <= (weff != target) ? S_SW_RD : S_LD_C;
        S_LD_C: state <= (weff != target) ? S_SW_RD : S_LD_D;
        S_LD_D: state <= (weff != target) ? S_SW_RD : S_RUN;
      endcase
    end

    // shift the window taps
    if (accept) begin
      n0 <= pixel;
      n1 <= n0;
      b1 <= r_rdata;
      b2 <= ctr_final;
      c1 <= f_rdata;
      c2 <= c1;
    end

    // reload taps after a sweep
    unique case (state)
      S_LD_B: begin
        b1 <= r_rdata;
        b2 <= f_rdata;
      end
      S_LD_C:  c1 <= f_rdata;
      S_LD_D:  c2 <= f_rdata;
      default: ;
    endcase

    // result payload
    if (accept && win) begin
      centre_value <= ctr_final;
      changed      <= hit;
      fill_count   <= fills_next;
      pass_done    <= last_pixel;
    end
  end

  // Effective width stays in the supported range
  assert property (@(posedge clk) disable iff (rst)
    (weff >= WW'(MIN_WIDTH)) && (weff <= WW'(MAX_WIDTH)))
    else $error("effective width out of range");

  // Each sweep write moves the effective width by exactly one
  assert property (@(posedge clk) disable iff (rst)
    state == S_SW_WR |=> (weff == $past(weff) + WW'(1)) || (weff == $past(weff) - WW'(1)))
    else $error("sweep step did not move width by one");

  // A completed window always yields a result beat
  assert property (@(posedge clk) disable iff (rst)
    accept && win |=> result_valid)
    else $error("completed window lost its result");

  // A fill shows up in the result as the fill value
  assert property (@(posedge clk) disable iff (rst)
    accept && hit |=> changed && (centre_value == $past(fill_value)))
    else $error("fill not reflected in result");

endmodule

`default_nettype wire

/* tb/window_pattern_fill_pass_tb.sv */
// Self-checking testbench for the window pattern fill pass: random and directed pixel streams.
`timescale 1ns / 1ps
`default_nettype none

module window_pattern_fill_pass_tb;
  import wpfp_pkg::*;

  localparam int LINE_DEPTH     = 2 * MAX_WIDTH_DEF + 3;
  localparam int RANDOM_ITEMS   = 400;
  localparam int SETTLE_CYCLES  = 8;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             last;
  } pixel_beat_t;

  typedef struct packed {
    logic [PIX_W-1:0] centre;
    logic             changed;
    logic [CNT_W-1:0] fills;
    logic             done;
  } centre_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  logic               pixel_valid = 1'b0;
  logic               pixel_stall;
  logic [PIX_W-1:0]   pixel       = '0;
  logic               last_pixel  = 1'b0;

  logic               result_valid;
  logic               result_stall = 1'b0;
  logic [PIX_W-1:0]   centre_value;
  logic               changed;
  logic [CNT_W-1:0]   fill_count;
  logic               pass_done;

  window_pattern_fill_pass i_dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .last_pixel  (last_pixel),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .centre_value(centre_value),
    .changed     (changed),
    .fill_count  (fill_count),
    .pass_done   (pass_done)
  );

  // Shadow copy of the register file
  logic             fill_set   = PATTERN_RST;
  logic [PIX_W-1:0] bg_level   = THRESHOLD_RST;
  logic [PIX_W-1:0] fill_pixel = FILL_RST;
  logic [LW_W-1:0]  width_reg  = LINE_WIDTH_RST;

  // Predicted image state
  logic [PIX_W-1:0] delay_line [LINE_DEPTH];
  int unsigned      wr_pos   = 0;
  logic [CNT_W-1:0] seen_cnt = '0;
  logic [CNT_W-1:0] fill_cnt = '0;

  pixel_beat_t  pixel_q[$];
  centre_beat_t pending_centres[$];

  // Run bookkeeping
  int unsigned mismatches      = 0;
  int unsigned pixels_accepted = 0;
  int unsigned passes_ended    = 0;
  int unsigned results_seen    = 0;
  int unsigned fills_seen      = 0;
  int unsigned stuck_cycles    = 0;
  logic        quiet           = 1'b0;
  logic        tx_idle_en      = 1'b0;
  logic        rx_idle_en      = 1'b0;

  pixel_beat_t  tx_beat;
  int unsigned  gap_left   = 0;
  int unsigned  stall_left = 0;
  int unsigned  hold_left  = 0;
  logic         long_done  = 1'b0;
  logic         stall_next;
  centre_beat_t want;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int unsigned clamp_width(input logic [LW_W-1:0] lw);
    int unsigned w;
    w = lw;
    if (w < MIN_WIDTH) w = MIN_WIDTH;
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    return w;
  endfunction

  function automatic int unsigned tap_at(input int unsigned back);
    return (wr_pos + LINE_DEPTH - back) % LINE_DEPTH;
  endfunction

  function automatic logic is_bg(input int unsigned back);
    return delay_line[tap_at(back)] <= bg_level;
  endfunction

  // Both sets are closed under quarter turns; match against the base shapes of each
  function automatic logic pattern_hit(input mask_t m, input logic sel);
    mask_t r;
    logic  hit;
    hit = 1'b0;
    r   = m;
    for (int k = 0; k < 4; k++) begin
      if (sel == PAT_LINE_END) begin
        hit |= (r == 8'hA7) || (r == 8'hCB) || (r == 8'hBE) ||
               (r == 8'hE0) || (r == 8'h06) || (r == 8'h0C);
      end else begin
        hit |= (r == 8'h2B) || (r == 8'hA9) || (r == 8'hAE);
      end
      // ring order runs down the bit indexes, so two places is a quarter turn
      r = {r[1:0], r[7:2]};
    end
    return hit;
  endfunction

  // Store one pixel, evaluate the window it completes and queue its centre beat
  function automatic void predict_centre(input logic [PIX_W-1:0] value, input logic last);
    int unsigned      w;
    int unsigned      c_idx;
    logic [PIX_W-1:0] centre;
    mask_t            nb;
    logic             hit;
    centre_beat_t     beat;
    w = clamp_width(width_reg);
    wr_pos = (wr_pos + 1) % LINE_DEPTH;
    delay_line[wr_pos] = value;
    if (seen_cnt != CNT_MAX) seen_cnt++;
    if (seen_cnt >= 2 * w + 3) begin
      c_idx  = tap_at(w + 1);
      centre = delay_line[c_idx];
      hit    = 1'b0;
      if (centre > bg_level) begin
        nb = {is_bg(0), is_bg(1), is_bg(2), is_bg(w + 2),
              is_bg(2 * w + 2), is_bg(2 * w + 1), is_bg(2 * w), is_bg(w)};
        hit = pattern_hit(nb, fill_set);
        if (hit) begin
          delay_line[c_idx] = fill_pixel;
          centre = fill_pixel;
          if (fill_cnt != CNT_MAX) fill_cnt++;
        end
      end
      beat.centre  = centre;
      beat.changed = hit;
      beat.fills   = fill_cnt;
      beat.done    = last;
      pending_centres.push_back(beat);
    end
    if (last) begin
      seen_cnt = '0;
      fill_cnt = '0;
    end
  endfunction

  function automatic logic [PIX_W-1:0] random_pixel();
    logic [PIX_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 255);
      1: v = $urandom_range(0, bg_level);
      default: begin
        v = (bg_level == 8'hFF) ? 8'hFF : $urandom_range(bg_level + 1, 255);
      end
    endcase
    return v;
  endfunction

  task automatic push_pixel(input logic [PIX_W-1:0] value, input logic last);
    pixel_beat_t b;
    b.value = value;
    b.last  = last;
    pixel_q.push_back(b);
  endtask

  // Push part of a width-3 window laid out so that its centre sees the given mask
  task automatic push_window3(input mask_t m, input logic [PIX_W-1:0] bg,
                              input logic [PIX_W-1:0] fg, input int lo, input int hi,
                              input logic ends);
    int bit_of;
    for (int p = lo; p <= hi; p++) begin
      case (p)
        0: bit_of = 3;
        1: bit_of = 2;
        2: bit_of = 1;
        3: bit_of = 4;
        5: bit_of = 0;
        6: bit_of = 5;
        7: bit_of = 6;
        8: bit_of = 7;
        default: bit_of = -1;
      endcase
      push_pixel((bit_of < 0) ? fg : (m[bit_of] ? bg : fg), ends && (p == hi));
    end
  endtask

  // Setup and access cycle; the register lands at the edge that sees pready
  task automatic write_reg(input cfg_reg_t r, input logic [PDATA_W-1:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      REG_PATTERN_SET: fill_set   = v[0];
      REG_THRESHOLD:   bg_level   = v[PIX_W-1:0];
      REG_FILL_VALUE:  fill_pixel = v[PIX_W-1:0];
      REG_LINE_WIDTH:  width_reg  = v[LW_W-1:0];
      default: ;
    endcase
  endtask

  // Hold until every pixel is in and every centre is out, then let the pipe settle
  task automatic wait_drained();
    do @(posedge clk); while (pixel_q.size() != 0 || pixel_valid || pending_centres.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Pixel driver: predict on each accepted beat, then present the next one
  always @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (pixel_valid && !pixel_stall) begin
        predict_centre(pixel, last_pixel);
        pixels_accepted++;
        if (last_pixel) passes_ended++;
      end
      if (!pixel_valid || !pixel_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          pixel_valid <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          tx_beat = pixel_q.pop_front();
          pixel       <= tx_beat.value;
          last_pixel  <= tx_beat.last;
          pixel_valid <= 1'b1;
          if (tx_idle_en && !quiet && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 16);
        end else begin
          pixel_valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: one long hold-off while pixels keep coming, else short bursts
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (!long_done && result_valid && pixel_q.size() >= 30) begin
        long_done  = 1'b1;
        hold_left  = LONG_HOLD - 1;
        stall_next = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        stall_next = 1'b1;
      end else if (rx_idle_en && !quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        stall_next = 1'b1;
      end else begin
        stall_next = 1'b0;
      end
      result_stall <= stall_next;
    end
  end

  // Result monitor: compare each beat against the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (changed) fills_seen++;
      if (pending_centres.size() == 0) begin
        $error("unexpected result beat: centre_value %0d", centre_value);
        mismatches++;
      end else begin
        want = pending_centres.pop_front();
        if (centre_value !== want.centre) begin
          $error("centre_value: expected %0d, got %0d", want.centre, centre_value);
          mismatches++;
        end
        if (changed !== want.changed) begin
          $error("changed: expected %0d, got %0d", want.changed, changed);
          mismatches++;
        end
        if (fill_count !== want.fills) begin
          $error("fill_count: expected %0d, got %0d", want.fills, fill_count);
          mismatches++;
        end
        if (pass_done !== want.done) begin
          $error("pass_done: expected %0d, got %0d", want.done, pass_done);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (pixel_valid && !pixel_stall) || (result_valid && !result_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == WATCHDOG_LIMIT) begin
      $display("Timeout: no beat for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, pending_centres.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int unsigned       random_items;
    int unsigned       n;
    logic              ends;
    logic              opening;
    logic [PDATA_W-1:0] v;
    random_items = 0;
    opening      = 1'b1;
    foreach (delay_line[i]) delay_line[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;

    // Short image at reset settings: ends before any window forms
    for (int i = 0; i < 3; i++) push_pixel($urandom_range(0, 255), i == 2);
    wait_drained();

    // T-junction fill; width drops mid-pass and an out-of-range width clamps up
    write_reg(REG_PATTERN_SET, {{(PDATA_W-1){1'b0}}, PAT_TJUNC});
    write_reg(REG_THRESHOLD, 32'hFFFF_FF5A);
    write_reg(REG_FILL_VALUE, 32'd200);
    write_reg(REG_LINE_WIDTH, 32'd4);
    push_window3(8'h2B, 8'h00, 8'hFF, 0, 4, 1'b0);
    wait_drained();
    write_reg(REG_LINE_WIDTH, 32'd1);
    push_window3(8'h2B, 8'h00, 8'hFF, 5, 8, 1'b1);
    wait_drained();

    // Line-end fill with background neighbours exactly at threshold and centre one above
    write_reg(REG_PATTERN_SET, {{(PDATA_W-1){1'b0}}, PAT_LINE_END});
    write_reg(REG_THRESHOLD, 32'd100);
    write_reg(REG_FILL_VALUE, 32'd0);
    push_window3(8'hA7, 8'd100, 8'd101, 0, 8, 1'b1);
    wait_drained();

    // Widest line via an oversized width value: a handful of windows
    write_reg(REG_LINE_WIDTH, 32'h0000_0FFF);
    write_reg(REG_FILL_VALUE, 32'd255);
    write_reg(REG_THRESHOLD, 32'd128);
    for (int i = 0; i < 2 * MAX_WIDTH_DEF + 6; i++) begin
      push_pixel(random_pixel(), i == 2 * MAX_WIDTH_DEF + 5);
    end
    wait_drained();

    // Random passes; some left open so the next settings land mid-pass
    while (random_items < RANDOM_ITEMS) begin
      if (opening || $urandom_range(0, 2) == 0) begin
        v = $urandom();
        case ($urandom_range(0, 9))
          0: v[LW_W-1:0] = $urandom_range(0, 2);
          1: v[LW_W-1:0] = $urandom_range(11, 40);
          default: v[LW_W-1:0] = $urandom_range(3, 10);
        endcase
        if (opening) v[LW_W-1:0] = 12'd3;
        write_reg(REG_LINE_WIDTH, v);
      end
      if ($urandom_range(0, 1) == 0) write_reg(REG_PATTERN_SET, $urandom());
      if ($urandom_range(0, 2) == 0) begin
        v = $urandom();
        case ($urandom_range(0, 5))
          0: v[PIX_W-1:0] = 8'h00;
          1: v[PIX_W-1:0] = 8'hFF;
          default: v[PIX_W-1:0] = $urandom_range(40, 200);
        endcase
        write_reg(REG_THRESHOLD, v);
      end
      if ($urandom_range(0, 2) == 0) write_reg(REG_FILL_VALUE, $urandom());
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      n    = opening ? 80 : $urandom_range(1, 2 * clamp_width(width_reg) + 40);
      ends = opening || ($urandom_range(0, 4) != 0);
      for (int i = 0; i < n; i++) push_pixel(random_pixel(), ends && (i == n - 1));
      random_items += n;
      if (random_items + 80 >= RANDOM_ITEMS) quiet = 1'b1;
      opening = 1'b0;
      wait_drained();
    end

    $display("Covered %0d pixel beats over %0d passes, %0d window results with %0d fills.",
             pixels_accepted, passes_ended, results_seen, fills_seen);
    $display("Widths 3 to 2048, both pattern sets, mid-pass width changes, stalls both sides.");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
